@@ src/bvrm_pkg.sv @@
// Shared types, constants and command structures for the battery voltage monitor.
package bvrm_pkg;

	localparam int SAMPLES_PER_READING = 8;
	localparam int SAMPLE_W = 12;
	localparam int IDX_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int CAL_W = 12;
	localparam int PROD_W = CAL_W + SAMPLE_W;
	localparam int NUM_W = 37;
	localparam int DEN_W = 24;
	localparam int MV_W = 13;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [15:0] CAL_LOW = 16'd1000;
	localparam logic [15:0] CAL_HIGH = 16'd3000;
	localparam logic [CAL_W-1:0] DEFAULT_CAL_RESET = 12'd1652;
	localparam logic [12:0] MV_SCALE = 13'd6000;
	localparam logic [MV_W-1:0] MV_LIMIT = 13'd5000;

	localparam logic REG_FACTORY_CAL = 1'b0;
	localparam logic REG_DEFAULT_CAL = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		CODE_OK = 2'd0,
		CODE_TIMEOUT = 2'd1,
		CODE_REF_ZERO = 2'd2
	} result_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ADD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic acc;
		logic restart;
		logic mul1;
		logic mul2;
		logic add;
		logic div_step;
		logic load;
		result_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic battery;
		logic ref_zero;
	} dp_stat_t;

endpackage

@@ src/bvrm_ctrl.sv @@
// Controller state machine that sequences accumulation, multiply, divide and output.
module bvrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               in_cmd,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  bvrm_pkg::dp_stat_t dp_stat,
	output bvrm_pkg::dp_cmd_t  dp_cmd
);
	import bvrm_pkg::*;

	state_t state_q, state_d;
	result_code_t code_q, code_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;
	logic accept;
	logic load;

	assign accept = s_tvalid && s_tready;
	assign load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		code_d = code_q;
		cnt_d = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_TIMEOUT) begin
						state_d = ST_EMIT;
						code_d = CODE_TIMEOUT;
					end else if (dp_stat.last && dp_stat.battery) begin
						if (dp_stat.ref_zero) begin
							state_d = ST_EMIT;
							code_d = CODE_REF_ZERO;
						end else begin
							state_d = ST_MUL1;
							code_d = CODE_OK;
						end
					end
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ADD;
			ST_ADD: begin
				state_d = ST_DIV;
				cnt_d = CNT_W'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		dp_cmd.acc = accept && (in_cmd == CMD_SAMPLE);
		dp_cmd.restart = accept && (in_cmd == CMD_TIMEOUT);
		dp_cmd.mul1 = (state_q == ST_MUL1);
		dp_cmd.mul2 = (state_q == ST_MUL2);
		dp_cmd.add = (state_q == ST_ADD);
		dp_cmd.div_step = (state_q == ST_DIV);
		dp_cmd.load = load;
		dp_cmd.code = code_q;
	end

	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q <= CODE_OK;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q <= code_d;
			cnt_q <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/bvrm_dp.sv @@
// Datapath with sample averaging, calibration registers, multiplier and restoring divider.
module bvrm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic [bvrm_pkg::SAMPLE_W-1:0]     in_sample,
	input  bvrm_pkg::dp_cmd_t                 dp_cmd,
	output bvrm_pkg::dp_stat_t                dp_stat,
	output logic [bvrm_pkg::MV_W-1:0]         out_mv,
	output bvrm_pkg::result_code_t            out_status,
	output logic                              out_clipped
);
	import bvrm_pkg::*;

	logic [15:0] factory_cal_q;
	logic [CAL_W-1:0] default_cal_q;
	logic battery_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [SAMPLE_W-1:0] ref_avg_q;
	logic [SAMPLE_W-1:0] vbat_avg_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [MV_W-1:0] mv_q;
	result_code_t status_q;
	logic clipped_q;

	logic [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] avg_full;
	logic last;
	logic [CAL_W-1:0] cal;
	logic [DEN_W:0] trial;
	logic take;
	logic over;

	assign sum_next = sum_q + SUM_W'(in_sample);
	assign avg_full = sum_next / SUM_W'(SAMPLES_PER_READING);
	assign last = (idx_q == IDX_W'(SAMPLES_PER_READING - 1));

	assign dp_stat.last = last;
	assign dp_stat.battery = battery_q;
	assign dp_stat.ref_zero = (ref_avg_q == '0);

	assign cal = (factory_cal_q < CAL_LOW || factory_cal_q > CAL_HIGH) ?
		default_cal_q : factory_cal_q[CAL_W-1:0];

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take = (trial >= {1'b0, den_q});
	assign over = (quo_q > NUM_W'(MV_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factory_cal_q <= '0;
			default_cal_q <= DEFAULT_CAL_RESET;
			battery_q <= 1'b0;
			idx_q <= '0;
			sum_q <= '0;
			ref_avg_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_FACTORY_CAL) begin
					factory_cal_q <= cfg_data;
				end else begin
					default_cal_q <= cfg_data[CAL_W-1:0];
				end
			end
			if (dp_cmd.restart) begin
				battery_q <= 1'b0;
				idx_q <= '0;
				sum_q <= '0;
			end else if (dp_cmd.acc) begin
				if (last) begin
					idx_q <= '0;
					sum_q <= '0;
					battery_q <= !battery_q;
					if (!battery_q) begin
						ref_avg_q <= avg_full[SAMPLE_W-1:0];
					end
				end else begin
					idx_q <= idx_q + 1'b1;
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.acc && last && battery_q) begin
			vbat_avg_q <= avg_full[SAMPLE_W-1:0];
		end
		if (dp_cmd.mul1) begin
			prod_q <= PROD_W'(cal) * PROD_W'(vbat_avg_q);
		end
		if (dp_cmd.mul2) begin
			num_q <= NUM_W'(prod_q) * NUM_W'(MV_SCALE);
			den_q <= {ref_avg_q, {(DEN_W - SAMPLE_W){1'b0}}} - DEN_W'(ref_avg_q);
		end
		if (dp_cmd.add) begin
			quo_q <= num_q + NUM_W'(den_q[DEN_W-1:1]);
			rem_q <= '0;
		end else if (dp_cmd.div_step) begin
			quo_q <= {quo_q[NUM_W-2:0], take};
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
		if (dp_cmd.load) begin
			status_q <= dp_cmd.code;
			if (dp_cmd.code != CODE_OK) begin
				mv_q <= '0;
				clipped_q <= 1'b0;
			end else if (over) begin
				mv_q <= MV_LIMIT;
				clipped_q <= 1'b1;
			end else begin
				mv_q <= quo_q[MV_W-1:0];
				clipped_q <= 1'b0;
			end
		end
	end

	assign out_mv = mv_q;
	assign out_status = status_q;
	assign out_clipped = clipped_q;

endmodule

@@ src/battery_voltage_ratiometric_monitor.sv @@
// Top level of the reference-compensated battery voltage monitor.
// The input stream carries one ADC conversion per beat: s_tdata holds the 12-bit
// sample and s_tuser says whether the beat is a sample or a conversion timeout.
// The first eight samples of a reading are the internal reference, the next
// eight are the battery divider. A timeout beat aborts the reading and yields a
// result beat with status timeout. Sample beats are taken back to back while
// the block is idle. Unless the reference average is zero, the last battery beat
// starts the result computation: the multiply steps ST_MUL1 and ST_MUL2, the add
// step ST_ADD and a restoring divider that retires one quotient bit per cycle.
// s_tready stays low until the result is loaded into the output register.
// Configuration writes on the cfg channel are always taken; index 0
// is the factory calibration word, index 1 the default calibration.
// Reset clears the reading in progress, the reference average and both
// calibration registers to their defaults. The result waits in an output register
// while m_tready is low; the block keeps taking sample beats meanwhile and stalls
// only when a new result is ready before the old one has gone.
module battery_voltage_ratiometric_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [11:0] sample, zero padded
	input  logic [0:0]  s_tuser,  // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [12:0] battery_mv, zero padded
	output logic [2:0]  m_tuser,  // [1:0] status, [2] clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import bvrm_pkg::*;

	dp_cmd_t dp_cmd;
	dp_stat_t dp_stat;
	logic [MV_W-1:0] out_mv;
	result_code_t out_status;
	logic out_clipped;

	assign cfg_ready = 1'b1;

	bvrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_cmd   (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	bvrm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_sample   (s_tdata[SAMPLE_W-1:0]),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.out_mv      (out_mv),
		.out_status  (out_status),
		.out_clipped (out_clipped)
	);

	assign m_tdata = {{(16 - MV_W){1'b0}}, out_mv};
	assign m_tuser = {out_clipped, out_status};

endmodule

@@ src/bvrm_checker.sv @@
// Port-level checker for the battery voltage monitor and its bind statement.
module bvrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import bvrm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result beat changed.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != CODE_OK |-> m_tdata == 16'd0 && !m_tuser[2])
		else $error("Error beat carries a voltage or a clip flag.");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 16'd5000 && m_tuser[1:0] <= CODE_REF_ZERO)
		else $error("Result beat out of range.");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == 16'd5000)
		else $error("Clipped beat is not at the limit.");

	a_timeout_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("Input taken while a timeout result is pending.");

endmodule

bind battery_voltage_ratiometric_monitor bvrm_checker u_bvrm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/battery_voltage_ratiometric_monitor_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the battery voltage monitor with a built-in reading predictor.
module battery_voltage_ratiometric_monitor_tb;
	import bvrm_pkg::*;

	localparam longint unsigned ADC_FULL_SCALE = 4095;

	typedef struct packed {
		logic [MV_W-1:0] mv;
		result_code_t status;
		logic clipped;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	reading_t expected_readings[$];

	logic in_battery_phase;
	int unsigned phase_count;
	int unsigned phase_sum;
	logic [SAMPLE_W-1:0] ref_average;
	logic [15:0] factory_cal_q;
	logic [CAL_W-1:0] default_cal_q;

	int errors = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int ok_count = 0;
	int clip_count = 0;
	int zero_ref_count = 0;
	int timeout_count = 0;
	int cal_settings = 1;
	bit no_gaps = 1'b0;
	int hold_cycles = 0;

	battery_voltage_ratiometric_monitor dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic note_mismatch(input string what, input reading_t want, input reading_t got);
		errors++;
		if (errors <= 10)
			$display("%0s: expected mv=%0d status=%0d clipped=%0d, got mv=%0d status=%0d clipped=%0d",
				what, want.mv, want.status, want.clipped, got.mv, got.status, got.clipped);
	endtask

	always @(posedge clk) begin : check_results
		reading_t got;
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mv = m_tdata[MV_W-1:0];
			got.status = result_code_t'(m_tuser[1:0]);
			got.clipped = m_tuser[2];
			results_seen++;
			if (expected_readings.size() == 0) begin
				want = '0;
				note_mismatch("unexpected result beat", want, got);
			end else begin
				want = expected_readings.pop_front();
				case (want.status)
					CODE_OK: ok_count++;
					CODE_TIMEOUT: timeout_count++;
					default: zero_ref_count++;
				endcase
				if (want.clipped)
					clip_count++;
				if (got.mv !== want.mv || got.status !== want.status || got.clipped !== want.clipped)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	task automatic predict_reading(input logic cmd, input logic [SAMPLE_W-1:0] smp);
		reading_t r;
		logic [SAMPLE_W-1:0] avg;
		logic [15:0] cal;
		longint unsigned num;
		longint unsigned den;
		longint unsigned mv;
		r = '0;
		if (cmd == CMD_TIMEOUT) begin
			in_battery_phase = 1'b0;
			phase_count = 0;
			phase_sum = 0;
			r.status = CODE_TIMEOUT;
			expected_readings.push_back(r);
			return;
		end
		phase_sum += 32'(smp);
		phase_count++;
		if (phase_count < SAMPLES_PER_READING)
			return;
		avg = SAMPLE_W'(phase_sum / SAMPLES_PER_READING);
		phase_count = 0;
		phase_sum = 0;
		if (!in_battery_phase) begin
			ref_average = avg;
			in_battery_phase = 1'b1;
			return;
		end
		in_battery_phase = 1'b0;
		if (ref_average == 0) begin
			r.status = CODE_REF_ZERO;
			expected_readings.push_back(r);
			return;
		end
		if (factory_cal_q < CAL_LOW || factory_cal_q > CAL_HIGH)
			cal = {4'b0, default_cal_q};
		else
			cal = factory_cal_q;
		num = 64'(MV_SCALE) * 64'(cal) * 64'(avg);
		den = ADC_FULL_SCALE * 64'(ref_average);
		mv = (num + den / 2) / den;
		r.status = CODE_OK;
		if (mv > 64'(MV_LIMIT)) begin
			r.mv = MV_LIMIT;
			r.clipped = 1'b1;
		end else begin
			r.mv = mv[MV_W-1:0];
		end
		expected_readings.push_back(r);
	endtask

	task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, smp};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		predict_reading(cmd, smp);
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
	endtask

	task automatic set_calibration(input logic [15:0] factory, input logic [CAL_W-1:0] dflt);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FACTORY_CAL;
		cfg_data <= factory;
		do @(posedge clk); while (!cfg_ready);
		factory_cal_q = factory;
		cfg_index <= REG_DEFAULT_CAL;
		cfg_data <= {4'b0, dflt};
		do @(posedge clk); while (!cfg_ready);
		default_cal_q = dflt;
		cfg_valid <= 1'b0;
		cal_settings++;
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] draw_sample(input int style);
		case (style)
			1: return SAMPLE_W'($urandom_range(0, 15));
			2: return SAMPLE_W'($urandom_range(3000, 4095));
			3: return SAMPLE_W'($urandom_range(0, 1));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// A broken reading stops at a random point and is aborted by a timeout beat.
	task automatic send_reading(input bit broken);
		int ref_style;
		int bat_style;
		int cut;
		ref_style = $urandom_range(0, 5);
		bat_style = $urandom_range(0, 4);
		cut = broken ? $urandom_range(0, 2 * SAMPLES_PER_READING - 1) : 2 * SAMPLES_PER_READING;
		for (int i = 0; i < cut; i++)
			send_beat(CMD_SAMPLE,
				draw_sample(i < SAMPLES_PER_READING ? ref_style : bat_style));
		if (broken)
			send_beat(CMD_TIMEOUT, draw_sample(0));
	endtask

	task automatic run_phase(input logic [15:0] factory, input logic [CAL_W-1:0] dflt,
			input int readings);
		set_calibration(factory, dflt);
		no_gaps = ($urandom_range(0, 2) == 0);
		repeat (readings) begin
			send_reading($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 7) == 0)
				send_beat(CMD_TIMEOUT, draw_sample(0));
		end
		wait_drained();
		no_gaps = 1'b0;
	endtask

	// Zero reference, timeout inside a reading and saturation, all at the reset calibration.
	task automatic test_special_cases();
		for (int i = 0; i < SAMPLES_PER_READING; i++)
			send_beat(CMD_SAMPLE, (i == SAMPLES_PER_READING - 1) ? 12'd7 : 12'd0);
		for (int i = 0; i < SAMPLES_PER_READING; i++)
			send_beat(CMD_SAMPLE, 12'd4095);
		send_beat(CMD_TIMEOUT, 12'd4095);
		for (int i = 0; i < 3; i++)
			send_beat(CMD_SAMPLE, 12'd4095);
		send_beat(CMD_TIMEOUT, 12'd0);
		for (int i = 0; i < SAMPLES_PER_READING; i++)
			send_beat(CMD_SAMPLE, 12'd1);
		for (int i = 0; i < SAMPLES_PER_READING; i++)
			send_beat(CMD_SAMPLE, 12'd4095);
		wait_drained();
	endtask

	// The receiver holds off long enough that the output register fills and input stalls.
	task automatic test_output_backpressure();
		hold_cycles = 200;
		repeat (4)
			send_beat(CMD_TIMEOUT, draw_sample(0));
		send_reading(1'b0);
		send_beat(CMD_TIMEOUT, draw_sample(0));
		wait_drained();
	endtask

	task automatic test_calibration_extremes();
		run_phase(16'd1000, 12'd1000, 3);
		run_phase(16'd3000, 12'd3000, 3);
		run_phase(16'd999, 12'd3000, 3);
		run_phase(16'd3001, 12'd1000, 3);
		run_phase(16'd65535, 12'd1000, 3);
		run_phase(16'd0, 12'd3000, 3);
	endtask

	task automatic test_random_calibration();
		logic [15:0] factory;
		repeat (4) begin
			if ($urandom_range(0, 1) == 0)
				factory = 16'($urandom_range(1000, 3000));
			else
				factory = 16'($urandom_range(0, 65535));
			run_phase(factory, CAL_W'($urandom_range(1000, 3000)), 3);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin : result_sink
			int stall;
			stall = no_gaps ? 0 : $urandom_range(0, 4);
			if (hold_cycles > 0) begin
				stall += hold_cycles;
				hold_cycles = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_SAMPLE;
		cfg_valid = 1'b0;
		cfg_index = REG_FACTORY_CAL;
		cfg_data = '0;
		factory_cal_q = 16'd0;
		default_cal_q = DEFAULT_CAL_RESET;
		in_battery_phase = 1'b0;
		phase_count = 0;
		phase_sum = 0;
		ref_average = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_output_backpressure();
		test_calibration_extremes();
		test_random_calibration();
		wait_drained();
		if (expected_readings.size() != 0) begin
			errors += expected_readings.size();
			$display("%0d expected results never arrived", expected_readings.size());
		end
		$display("Sent %0d input beats over %0d calibration settings; got %0d result beats.",
			beats_sent, cal_settings, results_seen);
		$display("Results: %0d ok (%0d saturated), %0d zero reference, %0d timeout, %0d errors.",
			ok_count, clip_count, zero_ref_count, timeout_count, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
